FILE: hw/rtl/csh_pkg.sv
// Shared types and constants for the collapsing sample history
package csh_pkg;

  localparam int unsigned HistoryDepth = 1024;
  localparam int unsigned Channels     = 4;
  localparam int unsigned InChannels   = 4;
  localparam int unsigned MaxLog       = 15;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned CountW       = 11;
  localparam int unsigned DataW        = 32;

  typedef enum logic [1:0] {
    HistScroll   = 2'd0,
    HistComplete = 2'd1,
    HistDiscard  = 2'd2,
    HistAverage  = 2'd3
  } hist_mode_e;

  typedef enum logic {
    OpAdd  = 1'b0,
    OpRead = 1'b1
  } op_e;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] x_value;
    logic signed [31:0] sample_0;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_2;
    logic signed [31:0] sample_3;
    logic [9:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_0;
    logic signed [31:0] out_1;
    logic signed [31:0] out_2;
    logic signed [31:0] out_3;
    logic               entry_valid;
    logic [10:0]        entry_count;
    logic               store_full;
  } out_item_t;

  // Lane control from the sequencer
  typedef struct packed {
    logic clear;   // drop group sum
    logic accum;   // add sample to group sum
    logic average; // pair-average the two read words
  } lane_ctrl_t;

endpackage

FILE: hw/rtl/csh_lane.sv
// One field lane: entry memory, group accumulator and pair averaging
module csh_lane #(
  parameter int unsigned Depth = csh_pkg::HistoryDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  csh_pkg::lane_ctrl_t     ctrl_i,
  input  logic [4:0]              shift_i,
  input  logic signed [31:0]      sample_i,
  // write port
  input  logic                    we_i,
  input  logic                    wsel_avg_i, // 1: write group average
  input  logic                    wsel_pair_i, // 1: write collapse result
  input  logic [AddrW-1:0]        waddr_i,
  // read ports
  input  logic [AddrW-1:0]        raddr_a_i,
  input  logic [AddrW-1:0]        raddr_b_i,
  output logic signed [31:0]      rdata_a_o
);

  logic signed [31:0] mem [Depth];
  logic signed [31:0] rd_a_q, rd_b_q;
  logic signed [47:0] sum_q, sum_d, sum_plus;
  logic signed [31:0] grp_avg, pair_res, wdata;
  logic signed [32:0] pair_sum;

  assign sum_plus = sum_q + 48'(sample_i);
  assign grp_avg  = 32'(sum_plus >>> shift_i);
  assign pair_sum = 33'(rd_a_q) + 33'(rd_b_q);
  assign pair_res = ctrl_i.average ? 32'(pair_sum >>> 1) : rd_a_q;

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.accum) begin
      sum_d = sum_plus;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_comb begin
    if (wsel_pair_i) begin
      wdata = pair_res;
    end else if (wsel_avg_i) begin
      wdata = grp_avg;
    end else begin
      wdata = sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata;
    end
    rd_a_q <= mem[raddr_a_i];
    rd_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;

endmodule

FILE: hw/rtl/csh_merge.sv
// Output stage: gathers lane read data into one result item
module csh_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                valid_i,
  input  logic [10:0]         count_i,
  input  logic                full_i,
  input  logic signed [31:0]  lane_x_i,
  input  logic signed [31:0]  lane_0_i,
  input  logic signed [31:0]  lane_1_i,
  input  logic signed [31:0]  lane_2_i,
  input  logic signed [31:0]  lane_3_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output csh_pkg::out_item_t  out_data_o
);

  logic busy_q, busy_d;
  csh_pkg::out_item_t data_q, data_d;

  always_comb begin
    busy_d = busy_q;
    data_d = data_q;
    if (busy_q && !out_stall_i) begin
      busy_d = 1'b0;
    end
    if (load_i) begin
      busy_d = 1'b1;
      data_d.entry_valid = valid_i;
      data_d.entry_count = count_i;
      data_d.store_full  = full_i;
      data_d.out_x = valid_i ? lane_x_i : '0;
      data_d.out_0 = valid_i ? lane_0_i : '0;
      data_d.out_1 = valid_i ? lane_1_i : '0;
      data_d.out_2 = valid_i ? lane_2_i : '0;
      data_d.out_3 = valid_i ? lane_3_i : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = busy_q;
  assign out_data_o  = data_q;

endmodule

FILE: hw/rtl/collapsing_sample_history.sv
// Top level: sequencer for the decimating sample history with five field lanes
//
//   channel  valid        stall        payload
//   in       in_valid_i   in_stall_o   in_data_i  (csh_pkg::in_item_t)
//   out      out_valid_o  out_stall_i  out_data_o (csh_pkg::out_item_t)
//   config   cfg_we_i     -            cfg_data_i
//
// An add is handled in StIdle alone; a read goes through the registered memory
// read and the output register. In discard and average modes an add that finds
// the store full is held while the pair reads start, HistoryDepth/2 pair steps
// run and StFinish settles. It is then taken as an ordinary add.
// Reset clears all control state; the entry memory is not cleared.
// A read is not taken while the output register holds an untaken result.
module collapsing_sample_history #(
  parameter int unsigned HistoryDepth = csh_pkg::HistoryDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  csh_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output csh_pkg::out_item_t out_data_o
);

  localparam int unsigned AddrW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int unsigned PosW  = $clog2(HistoryDepth + 1);
  localparam int unsigned Half  = HistoryDepth / 2;
  localparam int unsigned Lanes = 5;

  typedef enum logic [3:0] {
    StIdle     = 4'b0001,
    StRead     = 4'b0010,
    StCollapse = 4'b0100,
    StFinish   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  csh_pkg::hist_mode_e mode_q;
  logic [PosW-1:0] wpos_q, wpos_d;
  logic wrap_q, wrap_d, full_q, full_d;
  logic [15:0] fill_q, fill_d;
  logic [4:0]  glog_q, glog_d;
  logic [PosW-1:0] cidx_q, cidx_d;      // collapse pointer
  logic [10:0] count_q;
  logic rvalid_q;

  logic accept, is_add, at_full, need_collapse;
  logic [15:0] gsize;
  logic [PosW-1:0] count_now;
  logic [AddrW-1:0] raddr_a, raddr_b, waddr, phys;
  logic we, wsel_avg, wsel_pair, out_load, out_valid;
  csh_pkg::lane_ctrl_t lctrl;
  logic signed [31:0] lane_in [Lanes];
  logic signed [31:0] lane_rd [Lanes];
  logic [PosW:0] phys_sum;

  assign is_add  = (in_data_i.mode == csh_pkg::OpAdd);
  assign at_full = (wpos_q >= PosW'(HistoryDepth));
  assign gsize   = 16'(17'd1 << glog_q);
  assign need_collapse = is_add && at_full && (fill_q == '0) &&
                         (mode_q == csh_pkg::HistDiscard || mode_q == csh_pkg::HistAverage);
  assign count_now = (mode_q == csh_pkg::HistScroll && wrap_q) ?
                     PosW'(HistoryDepth) : wpos_q;

  assign in_stall_o = (state_q != StIdle) || need_collapse ||
                      (!is_add && out_valid && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;

  // chronological to physical index for a wrapped scroll store
  assign phys_sum = (PosW+1)'(wpos_q) + (PosW+1)'(in_data_i.read_index);
  always_comb begin
    if (mode_q == csh_pkg::HistScroll && wrap_q) begin
      phys = (phys_sum >= (PosW+1)'(HistoryDepth)) ?
             AddrW'(phys_sum - (PosW+1)'(HistoryDepth)) : AddrW'(phys_sum);
    end else begin
      phys = AddrW'(in_data_i.read_index);
    end
  end

  assign lane_in[0] = in_data_i.x_value;
  assign lane_in[1] = in_data_i.sample_0;
  assign lane_in[2] = in_data_i.sample_1;
  assign lane_in[3] = in_data_i.sample_2;
  assign lane_in[4] = in_data_i.sample_3;

  // sequencer
  always_comb begin
    state_d = state_q;
    wpos_d = wpos_q; wrap_d = wrap_q; full_d = full_q;
    fill_d = fill_q; glog_d = glog_q; cidx_d = cidx_q;
    we = 1'b0; wsel_avg = 1'b0; wsel_pair = 1'b0; waddr = AddrW'(wpos_q);
    raddr_a = phys; raddr_b = phys;
    lctrl = '0; out_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && need_collapse && state_q == StIdle) begin
          state_d = StCollapse;
          cidx_d  = '0;
          raddr_a = '0;
          raddr_b = AddrW'(1);
        end else if (accept && !is_add) begin
          state_d = StRead;
        end else if (accept) begin
          unique case (mode_q)
            csh_pkg::HistScroll: begin
              we = 1'b1;
              if (wpos_q + 1'b1 >= PosW'(HistoryDepth)) begin
                wpos_d = '0; wrap_d = 1'b1;
              end else begin
                wpos_d = wpos_q + 1'b1;
              end
            end
            csh_pkg::HistComplete: begin
              if (!at_full) begin
                we = 1'b1; wpos_d = wpos_q + 1'b1;
              end else begin
                full_d = 1'b1;
              end
            end
            csh_pkg::HistDiscard: begin
              if (fill_q == '0) begin
                we = 1'b1; wpos_d = wpos_q + 1'b1;
              end
              fill_d = (fill_q + 1'b1 >= gsize) ? '0 : fill_q + 1'b1;
            end
            default: begin
              if (fill_q + 1'b1 >= gsize) begin
                fill_d = '0; we = 1'b1; wsel_avg = 1'b1;
                wpos_d = wpos_q + 1'b1; lctrl.clear = 1'b1;
              end else begin
                fill_d = fill_q + 1'b1; lctrl.accum = 1'b1;
              end
            end
          endcase
        end
      end
      StRead: begin
        out_load = 1'b1;
        state_d  = StIdle;
      end
      StCollapse: begin
        // read pair j+1 while writing result j
        lctrl.average = (mode_q == csh_pkg::HistAverage);
        we = 1'b1; wsel_pair = 1'b1; waddr = AddrW'(cidx_q);
        raddr_a = AddrW'(2 * (cidx_q + 1'b1));
        raddr_b = AddrW'(2 * (cidx_q + 1'b1) + 1);
        cidx_d = cidx_q + 1'b1;
        if (cidx_q + 1'b1 >= PosW'(Half)) begin
          state_d = StFinish;
          wpos_d  = PosW'(Half);
          if (glog_q < 5'(csh_pkg::MaxLog)) begin
            glog_d = glog_q + 1'b1;
          end
        end
      end
      StFinish: begin
        // hold the pending sample; it is taken as an ordinary add next cycle
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q  <= csh_pkg::HistScroll;
      wpos_q <= '0; wrap_q <= 1'b0; full_q <= 1'b0;
      fill_q <= '0; glog_q <= '0; cidx_q <= '0;
      rvalid_q <= 1'b0; count_q <= '0;
    end else if (cfg_we_i) begin
      mode_q <= csh_pkg::hist_mode_e'(cfg_data_i);
      state_q <= StIdle;
      wpos_q <= '0; wrap_q <= 1'b0; full_q <= 1'b0;
      fill_q <= '0; glog_q <= '0; cidx_q <= '0;
    end else begin
      state_q <= state_d;
      wpos_q <= wpos_d; wrap_q <= wrap_d; full_q <= full_d;
      fill_q <= fill_d; glog_q <= glog_d; cidx_q <= cidx_d;
      if (accept && !is_add) begin
        rvalid_q <= (11'(in_data_i.read_index) < 11'(count_now));
        count_q  <= 11'(count_now);
      end
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    csh_lane #(.Depth(HistoryDepth), .AddrW(AddrW)) u_lane (
      .clk_i, .rst_ni,
      .ctrl_i(cfg_we_i ? csh_pkg::lane_ctrl_t'(3'b100) : lctrl),
      .shift_i(glog_q),
      .sample_i(lane_in[l]),
      .we_i(we && !cfg_we_i),
      .wsel_avg_i(wsel_avg),
      .wsel_pair_i(wsel_pair),
      .waddr_i(waddr),
      .raddr_a_i(raddr_a),
      .raddr_b_i(raddr_b),
      .rdata_a_o(lane_rd[l])
    );
  end

  csh_merge u_merge (
    .clk_i, .rst_ni,
    .load_i(out_load),
    .valid_i(rvalid_q),
    .count_i(count_q),
    .full_i(full_q),
    .lane_x_i(lane_rd[0]),
    .lane_0_i(lane_rd[1]),
    .lane_1_i(lane_rd[2]),
    .lane_2_i(lane_rd[3]),
    .lane_3_i(lane_rd[4]),
    .out_stall_i,
    .out_valid_o(out_valid),
    .out_data_o
  );

  assign out_valid_o = out_valid;

`ifndef SYNTHESIS
  a_wpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= PosW'(HistoryDepth)) else $error("write position beyond depth");
  a_collapse_halves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) |-> (wpos_q == PosW'(Half))) else $error("collapse end");
  a_no_write_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> !we) else $error("write during read");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q < gsize) || (fill_q == '0)) else $error("group fill overrun");
`endif

endmodule
